/* hdl/oai_pkg.sv */
// Shared constants and types for the ordered array insert/remove core.
// No dependencies; imported by the core top level and oai_ctrl.
package oai_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 5;
  localparam int COUNT_W  = 5;
  localparam int DATA_W   = 32;
  localparam int CMP_W    = (POS_W > CNT_W) ? POS_W : CNT_W;

  typedef enum logic [2:0] {
    REQ_APPEND = 3'd0,
    REQ_INSERT = 3'd1,
    REQ_REMOVE = 3'd2,
    REQ_READ   = 3'd3,
    REQ_UPDATE = 3'd4
  } req_kind_t;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic [1:0]               status;
    logic [COUNT_W-1:0]       count;
  } res_t;

endpackage

/* hdl/ordered_array_insert_remove_core.sv */
// Top level of the ordered array insert/remove core: output register and checks.
// Depends on oai_pkg and oai_ctrl.

// Fixed-capacity ordered list of signed 32-bit words (CAPACITY entries) kept in
// one synchronous RAM. Every accepted request returns one result with the
// count after the request. Append, update, insert at the count, remove of
// the last entry, unknown kinds and every rejected request go straight to
// the result; read waits for the registered RAM read; insert moves the
// entries from the position up and then writes the word; remove moves down
// the entries above the position. Moves go through the single RAM read and
// write port, one entry per cycle. A result can wait in the output register
// while the next request is taken.
module ordered_array_insert_remove_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [2:0]                        req_type,
  input  logic [oai_pkg::POS_W-1:0]         position,
  input  logic signed [oai_pkg::DATA_W-1:0] data_word,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [oai_pkg::DATA_W-1:0] read_value,
  output logic [1:0]                        status,
  output logic [oai_pkg::COUNT_W-1:0]       count
);
  import oai_pkg::*;

  logic res_valid;
  logic res_ready;
  res_t res;

  oai_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .req_type  (req_type),
    .position  (position),
    .data_word (data_word),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      read_value <= res.value;
      status     <= res.status;
      count      <= res.count;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (count <= COUNT_W'(CAPACITY)))
    else $error("count above capacity");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_FULL) |-> (count == COUNT_W'(CAPACITY)))
    else $error("full status with room left");

  a_err_value: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_RANGE) |-> (read_value == 0 || read_value == -1))
    else $error("bad value on range error");

  a_ok_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_OK || status == ST_FULL || status == ST_RANGE))
    else $error("undefined status code");

endmodule

/* hdl/oai_ram.sv */
// Simple dual-port RAM, one write and one registered read port.
// Generic; no package dependency.
module oai_ram #(
  parameter int DEPTH  = 16,
  parameter int WIDTH  = 32,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/oai_ctrl.sv */
// Request sequencer: bounds checks, fill count, and entry moves through the RAM.
// Depends on oai_pkg and oai_ram.
module oai_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [2:0]                  req_type,
  input  logic [oai_pkg::POS_W-1:0]   position,
  input  logic signed [oai_pkg::DATA_W-1:0] data_word,
  output logic                        res_valid,
  input  logic                        res_ready,
  output oai_pkg::res_t               res
);
  import oai_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SHIFT = 5'b00010,
    S_READ  = 5'b00100,
    S_PUT   = 5'b01000,
    S_HOLD  = 5'b10000
  } state_t;

  state_t             state;
  logic [CNT_W-1:0]   fill;
  logic [IDX_W-1:0]   src;
  logic [IDX_W-1:0]   last;
  logic               src_done;
  logic               pend;
  logic [IDX_W-1:0]   pend_dst;
  logic               ins;
  logic [IDX_W-1:0]   pos_r;
  logic [DATA_W-1:0]  word_r;

  logic               accept;
  logic               full;
  logic               ins_ok;
  logic               idx_ok;
  logic [CMP_W-1:0]   pos_c;
  logic [CMP_W-1:0]   fill_c;
  logic [IDX_W-1:0]   pos_idx;

  logic               we;
  logic [IDX_W-1:0]   waddr;
  logic [DATA_W-1:0]  wdata;
  logic               re;
  logic [IDX_W-1:0]   raddr;
  logic [DATA_W-1:0]  rdata;

  oai_ram #(.DEPTH(CAPACITY), .WIDTH(DATA_W)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign in_stall  = !((state == S_IDLE) || ((state == S_HOLD) && res_ready));
  assign accept    = in_valid && !in_stall;
  assign res_valid = (state == S_HOLD);

  assign pos_c   = CMP_W'(position);
  assign fill_c  = CMP_W'(fill);
  assign pos_idx = IDX_W'(position);
  assign full    = (fill_c >= CMP_W'(CAPACITY));
  assign ins_ok  = !full && (pos_c <= fill_c);
  assign idx_ok  = (pos_c < fill_c);

  always_comb begin
    we    = 1'b0;
    waddr = pos_idx;
    wdata = data_word;
    re    = 1'b0;
    raddr = pos_idx;
    if (accept) begin
      case (req_kind_t'(req_type))
        REQ_APPEND: begin
          we    = !full;
          waddr = IDX_W'(fill);
        end
        REQ_INSERT: we = ins_ok && (pos_c == fill_c);
        REQ_UPDATE: we = idx_ok;
        REQ_READ:   re = idx_ok;
        default: ;
      endcase
    end else if (state == S_SHIFT) begin
      we    = pend;
      waddr = pend_dst;
      wdata = rdata;
      re    = !src_done;
      raddr = src;
    end else if (state == S_PUT) begin
      we    = 1'b1;
      waddr = pos_r;
      wdata = word_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      fill     <= '0;
      pend     <= 1'b0;
      src_done <= 1'b0;
    end else begin
      unique case (state) inside
        S_IDLE, S_HOLD: begin
          if (accept) begin
            res.value  <= '0;
            res.status <= ST_OK;
            res.count  <= COUNT_W'(fill);
            state      <= S_HOLD;
            pos_r      <= pos_idx;
            word_r     <= data_word;
            src_done   <= 1'b0;
            pend       <= 1'b0;
            case (req_kind_t'(req_type))
              REQ_APPEND: begin
                if (full) begin
                  res.status <= ST_FULL;
                end else begin
                  fill      <= fill + 1'b1;
                  res.count <= COUNT_W'(fill + 1'b1);
                end
              end
              REQ_INSERT: begin
                if (full) begin
                  res.status <= ST_FULL;
                end else if (!ins_ok) begin
                  res.status <= ST_RANGE;
                end else begin
                  fill      <= fill + 1'b1;
                  res.count <= COUNT_W'(fill + 1'b1);
                  if (pos_c != fill_c) begin
                    src   <= IDX_W'(fill - 1'b1);
                    last  <= pos_idx;
                    ins   <= 1'b1;
                    state <= S_SHIFT;
                  end
                end
              end
              REQ_REMOVE: begin
                if (!idx_ok) begin
                  res.status <= ST_RANGE;
                end else begin
                  fill      <= fill - 1'b1;
                  res.count <= COUNT_W'(fill - 1'b1);
                  if (pos_c != fill_c - 1'b1) begin
                    src   <= pos_idx + 1'b1;
                    last  <= IDX_W'(fill - 1'b1);
                    ins   <= 1'b0;
                    state <= S_SHIFT;
                  end
                end
              end
              REQ_READ: begin
                if (!idx_ok) begin
                  res.status <= ST_RANGE;
                  res.value  <= '1;
                end else begin
                  state <= S_READ;
                end
              end
              REQ_UPDATE: begin
                if (!idx_ok) begin
                  res.status <= ST_RANGE;
                end
              end
              default: ;
            endcase
          end else if (state == S_HOLD && res_ready) begin
            state <= S_IDLE;
          end
        end
        S_SHIFT: begin
          if (!src_done) begin
            pend     <= 1'b1;
            pend_dst <= ins ? src + 1'b1 : src - 1'b1;
            if (src == last) begin
              src_done <= 1'b1;
            end else begin
              src <= ins ? src - 1'b1 : src + 1'b1;
            end
          end else begin
            pend  <= 1'b0;
            state <= ins ? S_PUT : S_HOLD;
          end
        end
        S_READ: begin
          res.value <= rdata;
          state     <= S_HOLD;
        end
        S_PUT: state <= S_HOLD;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
